>>> rtl/aunal_pkg.sv
// ----------------------------------------------------------------------------
// aunal_pkg
// Shared types and constants for the access unit NAL scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package aunal_pkg;

    localparam int DEF_POSITION_BITS = 24;
    localparam int OUT_LEN_BITS      = 24;
    localparam int NAL_TYPE_BITS     = 6;
    localparam int LEN_FIELD_BITS    = 32;
    localparam int LEN_PREFIX_BYTES  = 4;

    // hevc nal unit type classes
    localparam logic [NAL_TYPE_BITS-1:0] TYPE_VCL_MAX   = 6'd31;
    localparam logic [NAL_TYPE_BITS-1:0] TYPE_KEY_MIN   = 6'd16;
    localparam logic [NAL_TYPE_BITS-1:0] TYPE_KEY_MAX   = 6'd21;
    localparam logic [NAL_TYPE_BITS-1:0] TYPE_PARAM_MIN = 6'd32;
    localparam logic [NAL_TYPE_BITS-1:0] TYPE_PARAM_MAX = 6'd34;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic                    has_vcl;
        logic                    has_key;
        logic                    has_param_set;
        logic [OUT_LEN_BITS-1:0] param_set_prefix_len;
    } t_out_item;

endpackage

`default_nettype wire

>>> rtl/aunal_scan.sv
// ----------------------------------------------------------------------------
// aunal_scan
// Per-byte framing detection, nal unit tracking and type classification.
// Emits one summary item on the last byte of an access unit.
// ----------------------------------------------------------------------------
`default_nettype none

module aunal_scan
    import aunal_pkg::*;
#(
    parameter int POSITION_BITS = DEF_POSITION_BITS
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_xfer,
    input  wire t_in_item  i_item,
    output logic           o_res_valid,
    output t_out_item      o_res
);

    typedef enum logic [1:0] {
        MODE_UNDECIDED,
        MODE_START_CODE,
        MODE_LENGTH
    } t_mode;

    localparam logic [POSITION_BITS-1:0] POS_MAX   = '1;
    localparam logic [POSITION_BITS-1:0] POS_ONE   = POSITION_BITS'(1);
    localparam logic [POSITION_BITS-1:0] POS_TWO   = POSITION_BITS'(2);
    localparam logic [POSITION_BITS-1:0] POS_THREE = POSITION_BITS'(3);
    localparam logic [LEN_FIELD_BITS-1:0] LEN_ONE  = LEN_FIELD_BITS'(1);
    localparam logic [2:0] IDX_THREE = 3'd3;
    localparam logic [2:0] IDX_FULL  = 3'(LEN_PREFIX_BYTES);

    logic [POSITION_BITS-1:0]  r_pos, n_pos;
    t_mode                     r_mode, n_mode;
    logic [1:0]                r_zrun, n_zrun;
    logic                      r_expect, n_expect;
    logic [LEN_FIELD_BITS-1:0] r_lshift, n_lshift;
    logic [2:0]                r_lidx, n_lidx;
    logic [LEN_FIELD_BITS-1:0] r_remain, n_remain;
    logic [NAL_TYPE_BITS-1:0]  r_ptype, n_ptype;
    logic                      r_stop, n_stop;
    logic                      r_vcl, n_vcl;
    logic                      r_key, n_key;
    logic                      r_param, n_param;
    logic                      r_popen, n_popen;
    logic [POSITION_BITS-1:0]  r_pend, n_pend;
    logic                      r_await, n_await;

    logic [7:0]                b;
    logic [NAL_TYPE_BITS-1:0]  hdr_type;
    logic [POSITION_BITS-1:0]  pos_inc;
    logic [POSITION_BITS-1:0]  sc_end;
    logic [LEN_FIELD_BITS-1:0] shifted;
    logic [LEN_FIELD_BITS-1:0] remain_dec;
    logic [2:0]                idx_inc;
    logic                      cls_en;
    logic [NAL_TYPE_BITS-1:0]  cls_type;
    logic                      cls_ps;
    logic [POSITION_BITS+OUT_LEN_BITS-1:0] pend_wide;

    assign b          = i_item.data_byte;
    assign hdr_type   = b[6:1];
    assign pos_inc    = (r_pos == POS_MAX) ? POS_MAX : r_pos + POS_ONE;
    assign sc_end     = r_pos - ((r_zrun == 2'd3) ? POS_THREE : POS_TWO);
    assign shifted    = {r_lshift[LEN_FIELD_BITS-9:0], b};
    assign remain_dec = r_remain - LEN_ONE;
    assign idx_inc    = r_lidx + 3'd1;
    // a length-framed unit is classified from its held header type
    assign cls_type   = (r_mode == MODE_LENGTH && !r_expect) ? r_ptype : hdr_type;
    assign cls_ps     = (cls_type >= TYPE_PARAM_MIN) && (cls_type <= TYPE_PARAM_MAX);

    always_comb begin
        n_pos    = r_pos;
        n_mode   = r_mode;
        n_zrun   = r_zrun;
        n_expect = r_expect;
        n_lshift = r_lshift;
        n_lidx   = r_lidx;
        n_remain = r_remain;
        n_ptype  = r_ptype;
        n_stop   = r_stop;
        n_vcl    = r_vcl;
        n_key    = r_key;
        n_param  = r_param;
        n_popen  = r_popen;
        n_pend   = r_pend;
        n_await  = r_await;
        cls_en   = 1'b0;

        unique case (r_mode)
            MODE_START_CODE: begin
                if (r_expect) begin
                    cls_en   = 1'b1;
                    n_await  = cls_ps && r_popen;
                    n_expect = 1'b0;
                    n_zrun   = 2'd0;
                end else if (b == 8'd1 && r_zrun >= 2'd2) begin
                    if (r_await && r_popen) begin
                        n_pend = sc_end;
                    end
                    n_await  = 1'b0;
                    n_expect = 1'b1;
                    n_zrun   = 2'd0;
                end else if (b == 8'd0) begin
                    if (r_zrun != 2'd3) begin
                        n_zrun = r_zrun + 2'd1;
                    end
                end else begin
                    n_zrun = 2'd0;
                end
            end
            MODE_LENGTH: begin
                if (!r_stop) begin
                    if (r_expect) begin
                        n_ptype  = hdr_type;
                        n_expect = 1'b0;
                        n_remain = remain_dec;
                        cls_en   = (remain_dec == '0);
                    end else if (r_remain != '0) begin
                        n_remain = remain_dec;
                        cls_en   = (remain_dec == '0);
                    end else begin
                        n_lshift = shifted;
                        n_lidx   = idx_inc;
                        if (idx_inc >= IDX_FULL) begin
                            n_lidx = 3'd0;
                            if (shifted == '0) begin
                                n_stop = 1'b1;
                            end else begin
                                n_remain = shifted;
                                n_expect = 1'b1;
                            end
                            n_lshift = '0;
                        end
                    end
                    // unit complete: record it, extend the parameter-set run
                    if (cls_en && cls_ps && r_popen) begin
                        n_pend = pos_inc;
                    end
                end
            end
            default: begin
                n_lshift = shifted;
                n_lidx   = idx_inc;
                if (idx_inc == IDX_THREE && shifted == LEN_ONE) begin
                    n_mode   = MODE_START_CODE;
                    n_expect = 1'b1;
                end else if (idx_inc >= IDX_FULL) begin
                    n_lidx = 3'd0;
                    if (shifted == LEN_ONE) begin
                        n_mode   = MODE_START_CODE;
                        n_expect = 1'b1;
                    end else begin
                        n_mode = MODE_LENGTH;
                        if (shifted == '0) begin
                            n_stop = 1'b1;
                        end else begin
                            n_remain = shifted;
                            n_expect = 1'b1;
                        end
                    end
                    n_lshift = '0;
                end
                if (n_mode == MODE_START_CODE) begin
                    n_lshift = '0;
                    n_lidx   = 3'd0;
                end
            end
        endcase

        if (cls_en) begin
            if (cls_type <= TYPE_VCL_MAX) begin
                n_vcl = 1'b1;
            end
            if (cls_type >= TYPE_KEY_MIN && cls_type <= TYPE_KEY_MAX) begin
                n_key = 1'b1;
            end
            if (cls_ps) begin
                n_param = 1'b1;
            end else begin
                n_popen = 1'b0;
            end
        end

        n_pos = pos_inc;

        // open start-code unit runs to the final byte
        if (i_item.last_byte && n_mode == MODE_START_CODE && n_await && n_popen) begin
            n_pend = pos_inc;
        end
    end

    assign pend_wide = {{OUT_LEN_BITS{1'b0}}, n_pend};

    always_comb begin
        o_res_valid                = i_xfer && i_item.last_byte;
        o_res.has_vcl              = n_vcl;
        o_res.has_key              = n_key;
        o_res.has_param_set        = n_param;
        o_res.param_set_prefix_len = pend_wide[OUT_LEN_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_xfer && i_item.last_byte)) begin
            r_pos    <= '0;
            r_mode   <= MODE_UNDECIDED;
            r_zrun   <= 2'd0;
            r_expect <= 1'b0;
            r_lshift <= '0;
            r_lidx   <= 3'd0;
            r_remain <= '0;
            r_ptype  <= '0;
            r_stop   <= 1'b0;
            r_vcl    <= 1'b0;
            r_key    <= 1'b0;
            r_param  <= 1'b0;
            r_popen  <= 1'b1;
            r_pend   <= '0;
            r_await  <= 1'b0;
        end else if (i_xfer) begin
            r_pos    <= n_pos;
            r_mode   <= n_mode;
            r_zrun   <= n_zrun;
            r_expect <= n_expect;
            r_lshift <= n_lshift;
            r_lidx   <= n_lidx;
            r_remain <= n_remain;
            r_ptype  <= n_ptype;
            r_stop   <= n_stop;
            r_vcl    <= n_vcl;
            r_key    <= n_key;
            r_param  <= n_param;
            r_popen  <= n_popen;
            r_pend   <= n_pend;
            r_await  <= n_await;
        end
    end

endmodule

`default_nettype wire

>>> rtl/aunal_outq.sv
// ----------------------------------------------------------------------------
// aunal_outq
// Result register with one skid entry; input stalls only when the skid is full.
// ----------------------------------------------------------------------------
`default_nettype none

module aunal_outq
    import aunal_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    input  wire t_out_item  i_res,
    output logic            o_full,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output t_out_item       o_out_data
);

    logic      r_out_valid;
    logic      r_skid_valid;
    t_out_item r_out;
    t_out_item r_skid;
    logic      out_take;

    assign out_take    = r_out_valid && !i_out_stall;
    assign o_full      = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_take) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (!r_out_valid || out_take) begin
                r_out       <= i_res;
                r_out_valid <= 1'b1;
            end else begin
                r_skid       <= i_res;
                r_skid_valid <= 1'b1;
            end
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

endmodule

`default_nettype wire

>>> rtl/access_unit_nal_scanner_top.sv
// ----------------------------------------------------------------------------
// access_unit_nal_scanner_top
// Scans the bytes of an access unit for hevc nal unit types and reports the
// seen type classes and the end of the leading parameter-set run.
//
//   channel   direction   handshake               payload
//   in        input       i_in_valid/o_in_stall   t_in_item  (one byte)
//   out       output      o_out_valid/i_out_stall t_out_item (one per access unit)
//
// one byte per clock unless stalled; the summary is registered into the result
// register (or the skid entry if busy) on the transfer of the byte marked last.
// the per-byte state update is one level of compares, a 32-bit length and a position counter.
// reset (synchronous) clears all framing state; the scanner also returns to
// that state after each last byte.
// the input stalls only while both the result register and the skid entry hold
// untaken results.
// ----------------------------------------------------------------------------
`default_nettype none

module access_unit_nal_scanner_top
    import aunal_pkg::*;
#(
    parameter int POSITION_BITS = DEF_POSITION_BITS
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire t_in_item   i_in_data,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output t_out_item       o_out_data
);

    logic      in_xfer;
    logic      res_valid;
    t_out_item res;
    logic      q_full;

    assign o_in_stall = q_full;
    assign in_xfer    = i_in_valid && !q_full;

    aunal_scan #(
        .POSITION_BITS (POSITION_BITS)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_xfer      (in_xfer),
        .i_item      (i_in_data),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    aunal_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (res_valid),
        .i_res       (res),
        .o_full      (q_full),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire
